@@ rtl/assert_macros.svh @@
// Assertion macros shared by the deque RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during rst
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/cdq_pkg.sv @@
// Package with shared constants, codes and command type of the deque
`default_nettype none
package cdq_pkg;

  localparam int DEPTH    = 128;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = IDX_W + 1;
  localparam int CAP_W    = 8;
  localparam int CMP_W    = (CAP_W > CNT_W) ? CAP_W : CNT_W;
  localparam int WORD_W   = 32;
  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 2;
  localparam int S_DATA_W = WORD_W;
  localparam int S_USER_W = 8;
  localparam int M_DATA_W = ((2 * WORD_W + 2 + 7) / 8) * 8;
  localparam int M_USER_W = 8;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(128);

  localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INS_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_DEL_FRONT = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DEL_BACK  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_READ      = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic cfg_wr;
    logic exec;
    logic load;
  } cmd_t;

endpackage
`default_nettype wire

@@ rtl/cdq_ctrl.sv @@
// Controller state machine: request sequencing and output handshake
`default_nettype none
`include "assert_macros.svh"
module cdq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output cdq_pkg::cmd_t      cmd
);
  import cdq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free   = !m_tvalid || m_tready;
  assign cfg_ready  = (state == ST_IDLE);
  assign s_tready   = (state == ST_IDLE) && !cfg_valid;

  assign cmd.cfg_wr = cfg_valid && cfg_ready;
  assign cmd.exec   = s_tvalid && s_tready;
  assign cmd.load   = (state == ST_LOAD) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd.exec) begin
            state <= ST_READ;
          end
          if (m_tready) begin
            m_tvalid <= 1'b0;
          end
        end
        ST_READ: begin
          state <= ST_LOAD;
          if (m_tready) begin
            m_tvalid <= 1'b0;
          end
        end
        ST_LOAD: begin
          if (out_free) begin
            state    <= ST_IDLE;
            m_tvalid <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  `ASSERT_NEXT(a_load_shows_result, cmd.load, m_tvalid)
  `ASSERT_NEXT(a_result_held, state == ST_LOAD && m_tvalid && !m_tready, state == ST_LOAD)

endmodule
`default_nettype wire

@@ rtl/cdq_dpath.sv @@
// Datapath: ring store, front and back indices, capacity and result registers
`default_nettype none
`include "assert_macros.svh"
module cdq_dpath (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire cdq_pkg::cmd_t                  cmd,
  input  wire logic [cdq_pkg::CAP_W-1:0]      cfg_data,
  input  wire logic [cdq_pkg::FUNC_W-1:0]     func,
  input  wire logic [cdq_pkg::WORD_W-1:0]     value,
  output logic      [cdq_pkg::STATUS_W-1:0]   status,
  output logic      [cdq_pkg::WORD_W-1:0]     front_value,
  output logic      [cdq_pkg::WORD_W-1:0]     back_value,
  output logic                                is_empty,
  output logic                                is_full
);
  import cdq_pkg::*;

  function automatic logic [CNT_W-1:0] eff_cap_f(input logic [CAP_W-1:0] c);
    logic [CMP_W-1:0] w;
    w = CMP_W'(c);
    if (w == '0) w = CMP_W'(1);
    if (w > CMP_W'(DEPTH)) w = CMP_W'(DEPTH);
    return CNT_W'(w);
  endfunction

  logic [WORD_W-1:0]   ring [DEPTH];
  logic [IDX_W-1:0]    front_index, front_index_next;
  logic [IDX_W-1:0]    back_index, back_index_next;
  logic                empty, empty_next;
  logic [CNT_W-1:0]    eff_cap;
  logic [STATUS_W-1:0] status_q, status_next;
  logic [WORD_W-1:0]   rd_front, rd_back;

  logic                wr_en;
  logic [IDX_W-1:0]    wr_slot;
  logic [CNT_W-1:0]    f_inc, b_inc;
  logic [IDX_W-1:0]    f_nxt, b_nxt, f_prv, b_prv;
  logic                full_now;

  always_comb begin
    f_inc = CNT_W'(front_index) + CNT_W'(1);
    b_inc = CNT_W'(back_index) + CNT_W'(1);
    f_nxt = (f_inc >= eff_cap) ? '0 : IDX_W'(f_inc);
    b_nxt = (b_inc >= eff_cap) ? '0 : IDX_W'(b_inc);
    f_prv = (front_index == '0 || CNT_W'(front_index) >= eff_cap) ?
            IDX_W'(eff_cap - CNT_W'(1)) : front_index - IDX_W'(1);
    b_prv = (back_index == '0 || CNT_W'(back_index) >= eff_cap) ?
            IDX_W'(eff_cap - CNT_W'(1)) : back_index - IDX_W'(1);
    full_now = !empty && (b_nxt == front_index);
  end

  always_comb begin
    front_index_next = front_index;
    back_index_next  = back_index;
    empty_next       = empty;
    status_next      = ST_DONE;
    wr_en            = 1'b0;
    wr_slot          = '0;
    case (func)
      FN_INS_FRONT, FN_INS_BACK: begin
        if (full_now) begin
          status_next = ST_OVERFLOW;
        end else if (empty) begin
          front_index_next = '0;
          back_index_next  = '0;
          empty_next       = 1'b0;
          wr_en            = 1'b1;
        end else if (func == FN_INS_FRONT) begin
          front_index_next = f_prv;
          wr_slot          = f_prv;
          wr_en            = 1'b1;
        end else begin
          back_index_next = b_nxt;
          wr_slot         = b_nxt;
          wr_en           = 1'b1;
        end
      end
      FN_DEL_FRONT, FN_DEL_BACK: begin
        if (empty) begin
          status_next = ST_UNDERFLOW;
        end else if (front_index == back_index) begin
          front_index_next = '0;
          back_index_next  = '0;
          empty_next       = 1'b1;
        end else if (func == FN_DEL_FRONT) begin
          front_index_next = f_nxt;
        end else begin
          back_index_next = b_prv;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_index <= '0;
      back_index  <= '0;
      empty       <= 1'b1;
      eff_cap     <= eff_cap_f(CAP_RESET);
    end else if (cmd.cfg_wr) begin
      front_index <= '0;
      back_index  <= '0;
      empty       <= 1'b1;
      eff_cap     <= eff_cap_f(cfg_data);
    end else if (cmd.exec) begin
      front_index <= front_index_next;
      back_index  <= back_index_next;
      empty       <= empty_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      ring[wr_slot] <= value;
    end
    rd_front <= ring[front_index];
    rd_back  <= ring[back_index];
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_q <= status_next;
    end
    if (cmd.load) begin
      status      <= status_q;
      front_value <= empty ? '1 : rd_front;
      back_value  <= empty ? '1 : rd_back;
      is_empty    <= empty;
      is_full     <= full_now;
    end
  end

  `ASSERT_IMPL(a_idx_in_range, 1'b1,
    CNT_W'(front_index) < eff_cap && CNT_W'(back_index) < eff_cap)
  `ASSERT_IMPL(a_empty_at_zero, empty, front_index == '0 && back_index == '0)
  `ASSERT_NEXT(a_cfg_clears, cmd.cfg_wr, empty)

endmodule
`default_nettype wire

@@ rtl/circular_deque_top.sv @@
// Top level of the ring-store double-ended queue
//
//  channel | direction | handshake           | payload
//  s_      | in        | s_tvalid / s_tready | s_tdata value, s_tuser func
//  m_      | out       | m_tvalid / m_tready | m_tdata values and flags, m_tuser status
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_data capacity
//
// Each request passes through index update and ring write, a registered two-port
// ring read, and result load into the output register once that is free.
// A request is taken while an earlier result still waits; its result loads once
// that one is taken, and s_tready stays low until then.
// Reset (synchronous): deque empty, capacity 128. A capacity write also empties it.
`default_nettype none
module circular_deque_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [cdq_pkg::S_DATA_W-1:0]  s_tdata,   // [31:0] value
  input  wire logic [cdq_pkg::S_USER_W-1:0]  s_tuser,   // [2:0] func
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [cdq_pkg::M_DATA_W-1:0]  m_tdata,   // [31:0] front_value,
                                                        // [63:32] back_value,
                                                        // [64] is_empty, [65] is_full
  output logic      [cdq_pkg::M_USER_W-1:0]  m_tuser,   // [1:0] status
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [cdq_pkg::CAP_W-1:0]     cfg_data   // [7:0] capacity
);
  import cdq_pkg::*;

  cmd_t                cmd;
  logic [STATUS_W-1:0] status;
  logic [WORD_W-1:0]   front_value;
  logic [WORD_W-1:0]   back_value;
  logic                is_empty;
  logic                is_full;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cmd       (cmd)
  );

  cdq_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_data    (cfg_data),
    .func        (s_tuser[FUNC_W-1:0]),
    .value       (s_tdata[WORD_W-1:0]),
    .status      (status),
    .front_value (front_value),
    .back_value  (back_value),
    .is_empty    (is_empty),
    .is_full     (is_full)
  );

  assign m_tdata = M_DATA_W'({is_full, is_empty, back_value, front_value});
  assign m_tuser = M_USER_W'(status);

endmodule
`default_nettype wire
